>>> rtl/convex_hull_max_triangle_area_core_assert.svh
// assertion macros shared by the largest hull triangle block
`ifndef CONVEX_HULL_MAX_TRIANGLE_AREA_CORE_ASSERT_SVH
`define CONVEX_HULL_MAX_TRIANGLE_AREA_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CHMTA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CHMTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/chmta_pkg.sv
// types and constants of the largest hull triangle block
package chmta_pkg;

    localparam int COORD_BITS = 16;
    // exact coordinate difference
    localparam int DW = COORD_BITS + 1;
    // full product of two differences
    localparam int PW = 2 * DW;
    // cross products and squared distances wrap at this width
    localparam int AW = 64;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   last_point;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] twice_area;
        logic        too_few_points;
    } t_out_beat;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic signed [AW-1:0] cprod;
        logic                 nearer;
    } t_cmp_res;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SWP_RD,
        ST_SWP_W0,
        ST_SWP_W1,
        ST_KEY_A,
        ST_KEY_D,
        ST_PREV_A,
        ST_PREV_D,
        ST_SORT_CMP,
        ST_PUT,
        ST_SCAN_A,
        ST_SCAN_D,
        ST_SCAN_CMP,
        ST_POP_D,
        ST_TRI_GO,
        ST_TRI_I,
        ST_TRI_ID,
        ST_TRI_JD,
        ST_TRI_KD,
        ST_TRI_TK,
        ST_TRI_K1D,
        ST_TRI_K1C,
        ST_DONE
    } t_state;

endpackage

>>> rtl/chmta_ram.sv
// generic simple dual port ram with registered read
module chmta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/chmta_cross.sv
// shared multiplier unit: cross product about o, optional squared distance compare
module chmta_cross import chmta_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_dist,
    input  t_point   i_o,
    input  t_point   i_a,
    input  t_point   i_b,
    output t_cmp_res o_res
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_dist;
    logic [2:0]           r_ph;
    logic signed [DW-1:0] r_dxa, r_dya, r_dxb, r_dyb;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] r_cross;
    logic [AW-1:0]        r_da;
    logic                 r_nearer;

    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [AW-1:0] prod_ext;
    logic signed [AW-1:0] cross_nxt;
    logic [AW-1:0]        db_nxt;

    always_comb begin
        case (r_ph)
            3'd0: begin mul_a = r_dxa; mul_b = r_dyb; end
            3'd1: begin mul_a = r_dxb; mul_b = r_dya; end
            3'd3: begin mul_a = r_dxa; mul_b = r_dxa; end
            3'd4: begin mul_a = r_dya; mul_b = r_dya; end
            3'd5: begin mul_a = r_dxb; mul_b = r_dxb; end
            3'd6: begin mul_a = r_dyb; mul_b = r_dyb; end
            default: begin mul_a = r_dxa; mul_b = r_dyb; end
        endcase
    end

    assign prod_ext  = AW'(r_prod);
    assign cross_nxt = r_acc - prod_ext;
    assign db_nxt    = $unsigned(r_acc + prod_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= 3'd0;
            end else if (r_busy) begin
                r_ph <= r_ph + 3'd1;
                if ((r_ph == 3'd2 && (!r_dist || cross_nxt != '0)) || r_ph == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dist <= i_dist;
            r_dxa  <= DW'(i_a.x) - DW'(i_o.x);
            r_dya  <= DW'(i_a.y) - DW'(i_o.y);
            r_dxb  <= DW'(i_b.x) - DW'(i_o.x);
            r_dyb  <= DW'(i_b.y) - DW'(i_o.y);
        end
        r_prod <= mul_a * mul_b;
        if (r_busy) begin
            case (r_ph)
                3'd1: r_acc <= prod_ext;
                3'd2: begin
                    r_cross  <= cross_nxt;
                    r_nearer <= 1'b0;
                end
                3'd4: r_acc <= prod_ext;
                3'd5: r_da <= $unsigned(r_acc + prod_ext);
                3'd6: r_acc <= prod_ext;
                3'd7: r_nearer <= (r_da < db_nxt);
                default: ;
            endcase
        end
    end

    assign o_res.busy   = r_busy;
    assign o_res.done   = r_done;
    assign o_res.cprod  = r_cross;
    assign o_res.nearer = r_nearer;

endmodule

>>> rtl/convex_hull_max_triangle_area_core.sv
// top level: point store, angular sort, hull scan and largest triangle search
// Points load at one beat per cycle until the beat marked last_point; beats past
// MAX_POINTS are dropped but a dropped last beat still closes the set. A set of
// fewer than three points answers at once with zero and too_few_points. Otherwise
// the block stops taking beats and runs an insertion sort by angle about the
// leftmost (then lowest) point, a Graham scan into the hull memory and a rotating
// search for the largest triangle, all through one shared multiplier unit, which
// finds a cross product and, on a tie on angle, compares squared distances. The
// sort makes up to n*n/2 compares on reversed input and the triangle search is of
// order h*h evaluations for h hull vertices. The result waits in an output
// register while the next set loads; only the closing beat waits for it to empty.
module convex_hull_max_triangle_area_core import chmta_pkg::*; #(
    parameter int MAX_POINTS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    `include "convex_hull_max_triangle_area_core_assert.svh"

    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int CW1 = CW + 1;
    localparam int SAW = $clog2(MAX_POINTS);
    localparam int PTW = $bits(t_point);

    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_n, n_n;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_j, n_j;
    logic [CW-1:0]        r_k, n_k;
    logic [CW-1:0]        r_h, n_h;
    logic [SAW-1:0]       r_aidx, n_aidx;
    t_point               r_anc, n_anc;
    t_point               r_key, n_key;
    t_point               r_prev, n_prev;
    t_point               r_p, n_p;
    t_point               r_t1, n_t1;
    t_point               r_t2, n_t2;
    t_point               r_hi, n_hi;
    t_point               r_hj, n_hj;
    logic signed [AW-1:0] r_tk, n_tk;
    logic signed [AW-1:0] r_best, n_best;
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out, n_out;

    logic           s_we;
    logic [SAW-1:0] s_waddr, s_raddr;
    t_point         s_wdata, s_rdata;
    logic           h_we;
    logic [CW-1:0]  h_waddr, h_raddr;
    t_point         h_wdata, h_rdata;

    logic     cmp_start, cmp_dist;
    t_point   cmp_o, cmp_a, cmp_b;
    t_cmp_res cmp_res;

    logic                 in_acc, out_free;
    logic [CW-1:0]        cnt_now, kk;
    t_point               in_pt;
    logic                 fin;
    logic signed [AW-1:0] fin_a;

    chmta_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    chmta_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS + 1)) u_hull (
        .i_clk  (i_clk),
        .i_we   (h_we),
        .i_waddr(h_waddr),
        .i_wdata(h_wdata),
        .i_raddr(h_raddr),
        .o_rdata(h_rdata)
    );

    chmta_cross u_cross (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(cmp_start),
        .i_dist (cmp_dist),
        .i_o    (cmp_o),
        .i_a    (cmp_a),
        .i_b    (cmp_b),
        .o_res  (cmp_res)
    );

    assign out_free = !r_out_valid || i_ready;
    // only the closing beat can need the output register
    assign o_ready  = (r_state == ST_LOAD) && (out_free || !i_data.last_point);
    assign in_acc   = i_valid && o_ready;
    assign in_pt.x  = i_data.point_x;
    assign in_pt.y  = i_data.point_y;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_h         = r_h;
        n_aidx      = r_aidx;
        n_anc       = r_anc;
        n_key       = r_key;
        n_prev      = r_prev;
        n_p         = r_p;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_hi        = r_hi;
        n_hj        = r_hj;
        n_tk        = r_tk;
        n_best      = r_best;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        s_we        = 1'b0;
        s_waddr     = '0;
        s_wdata     = '0;
        s_raddr     = '0;
        h_we        = 1'b0;
        h_waddr     = '0;
        h_wdata     = '0;
        h_raddr     = '0;
        cmp_start   = 1'b0;
        cmp_dist    = 1'b0;
        cmp_o       = r_anc;
        cmp_a       = r_key;
        cmp_b       = s_rdata;
        cnt_now     = r_cnt;
        kk          = r_k;
        fin         = 1'b0;
        fin_a       = r_tk;

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (r_cnt < CW'(MAX_POINTS)) begin
                        s_we    = 1'b1;
                        s_waddr = r_cnt[SAW-1:0];
                        s_wdata = in_pt;
                        if (r_cnt == '0 || in_pt.x < r_anc.x ||
                            (in_pt.x == r_anc.x && in_pt.y < r_anc.y)) begin
                            n_anc  = in_pt;
                            n_aidx = r_cnt[SAW-1:0];
                        end
                        cnt_now = r_cnt + CW'(1);
                    end
                    n_cnt = cnt_now;
                    if (i_data.last_point) begin
                        n_cnt = '0;
                        if (cnt_now < CW'(3)) begin
                            n_out_valid          = 1'b1;
                            n_out.twice_area     = '0;
                            n_out.too_few_points = 1'b1;
                            n_aidx               = '0;
                        end else begin
                            n_n     = cnt_now;
                            n_state = ST_SWP_RD;
                        end
                    end
                end
            end
            ST_SWP_RD: begin
                s_raddr = '0;
                n_state = ST_SWP_W0;
            end
            ST_SWP_W0: begin
                s_we    = 1'b1;
                s_waddr = r_aidx;
                s_wdata = s_rdata;
                n_state = ST_SWP_W1;
            end
            ST_SWP_W1: begin
                s_we    = 1'b1;
                s_waddr = '0;
                s_wdata = r_anc;
                n_i     = CW'(2);
                n_state = ST_KEY_A;
            end
            ST_KEY_A: begin
                s_raddr = r_i[SAW-1:0];
                n_state = ST_KEY_D;
            end
            ST_KEY_D: begin
                n_key   = s_rdata;
                n_j     = r_i;
                n_state = ST_PREV_A;
            end
            ST_PREV_A: begin
                s_raddr = r_j[SAW-1:0] - SAW'(1);
                n_state = ST_PREV_D;
            end
            ST_PREV_D: begin
                n_prev    = s_rdata;
                cmp_start = 1'b1;
                cmp_dist  = 1'b1;
                cmp_o     = r_anc;
                cmp_a     = r_key;
                cmp_b     = s_rdata;
                n_state   = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                if (cmp_res.done) begin
                    if (cmp_res.cprod > 0 || (cmp_res.cprod == 0 && cmp_res.nearer)) begin
                        // key goes in front: shift the earlier point up one place
                        s_we    = 1'b1;
                        s_waddr = r_j[SAW-1:0];
                        s_wdata = r_prev;
                        n_j     = r_j - CW'(1);
                        n_state = (r_j > CW'(2)) ? ST_PREV_A : ST_PUT;
                    end else begin
                        n_state = ST_PUT;
                    end
                end
            end
            ST_PUT: begin
                s_we    = 1'b1;
                s_waddr = r_j[SAW-1:0];
                s_wdata = r_key;
                n_i     = r_i + CW'(1);
                if ((r_i + CW'(1)) < r_n) begin
                    n_state = ST_KEY_A;
                end else begin
                    n_i     = '0;
                    n_h     = '0;
                    n_state = ST_SCAN_A;
                end
            end
            ST_SCAN_A: begin
                s_raddr = r_i[SAW-1:0];
                n_state = ST_SCAN_D;
            end
            ST_SCAN_D: begin
                n_p = s_rdata;
                if (r_h >= CW'(2)) begin
                    cmp_start = 1'b1;
                    cmp_o     = r_t2;
                    cmp_a     = r_t1;
                    cmp_b     = s_rdata;
                    n_state   = ST_SCAN_CMP;
                end else begin
                    h_we    = 1'b1;
                    h_waddr = r_h;
                    h_wdata = s_rdata;
                    n_t2    = r_t1;
                    n_t1    = s_rdata;
                    n_h     = r_h + CW'(1);
                    n_i     = r_i + CW'(1);
                    n_state = ((r_i + CW'(1)) < r_n) ? ST_SCAN_A : ST_TRI_GO;
                end
            end
            ST_SCAN_CMP: begin
                if (cmp_res.done) begin
                    if (cmp_res.cprod <= 0 && r_h != CW'(2)) begin
                        // pop and fetch the new second-from-top vertex
                        n_h     = r_h - CW'(1);
                        n_t1    = r_t2;
                        h_raddr = r_h - CW'(3);
                        n_state = ST_POP_D;
                    end else begin
                        if (cmp_res.cprod <= 0) begin
                            // pop to one vertex, then push replaces the top
                            h_waddr = CW'(1);
                            n_t1    = r_p;
                        end else begin
                            h_waddr = r_h;
                            n_t2    = r_t1;
                            n_t1    = r_p;
                            n_h     = r_h + CW'(1);
                        end
                        h_we    = 1'b1;
                        h_wdata = r_p;
                        n_i     = r_i + CW'(1);
                        n_state = ((r_i + CW'(1)) < r_n) ? ST_SCAN_A : ST_TRI_GO;
                    end
                end
            end
            ST_POP_D: begin
                n_t2      = h_rdata;
                cmp_start = 1'b1;
                cmp_o     = h_rdata;
                cmp_a     = r_t1;
                cmp_b     = r_p;
                n_state   = ST_SCAN_CMP;
            end
            ST_TRI_GO: begin
                n_best = '0;
                if (r_h < CW'(3)) begin
                    n_state = ST_DONE;
                end else begin
                    n_i     = '0;
                    n_k     = CW'(2);
                    n_state = ST_TRI_I;
                end
            end
            ST_TRI_I: begin
                h_raddr = r_i;
                n_state = ST_TRI_ID;
            end
            ST_TRI_ID: begin
                n_hi    = h_rdata;
                n_j     = r_i + CW'(1);
                h_raddr = r_i + CW'(1);
                n_state = ST_TRI_JD;
            end
            ST_TRI_JD: begin
                n_hj    = h_rdata;
                kk      = (r_k <= r_j) ? (r_j + CW'(1)) : r_k;
                n_k     = kk;
                h_raddr = kk;
                n_state = ST_TRI_KD;
            end
            ST_TRI_KD: begin
                cmp_start = 1'b1;
                cmp_o     = r_hi;
                cmp_a     = r_hj;
                cmp_b     = h_rdata;
                n_state   = ST_TRI_TK;
            end
            ST_TRI_TK: begin
                if (cmp_res.done) begin
                    n_tk = cmp_res.cprod;
                    if ((CW1'(r_k) + CW1'(1)) < CW1'(r_h)) begin
                        h_raddr = r_k + CW'(1);
                        n_state = ST_TRI_K1D;
                    end else begin
                        fin   = 1'b1;
                        fin_a = cmp_res.cprod;
                    end
                end
            end
            ST_TRI_K1D: begin
                cmp_start = 1'b1;
                cmp_o     = r_hi;
                cmp_a     = r_hj;
                cmp_b     = h_rdata;
                n_state   = ST_TRI_K1C;
            end
            ST_TRI_K1C: begin
                if (cmp_res.done) begin
                    if (cmp_res.cprod > r_tk) begin
                        n_k  = r_k + CW'(1);
                        n_tk = cmp_res.cprod;
                        if ((CW1'(r_k) + CW1'(2)) < CW1'(r_h)) begin
                            h_raddr = r_k + CW'(2);
                            n_state = ST_TRI_K1D;
                        end else begin
                            fin   = 1'b1;
                            fin_a = cmp_res.cprod;
                        end
                    end else begin
                        fin   = 1'b1;
                        fin_a = r_tk;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.twice_area     = r_best[31:0];
                    n_out.too_few_points = 1'b0;
                    n_aidx               = '0;
                    n_state              = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        // close one j step of the triangle search
        if (fin) begin
            if (fin_a > r_best) begin
                n_best = fin_a;
            end
            n_j = r_j + CW'(1);
            if ((CW1'(r_j) + CW1'(2)) < CW1'(r_h)) begin
                h_raddr = r_j + CW'(1);
                n_state = ST_TRI_JD;
            end else begin
                n_i = r_i + CW'(1);
                if ((CW1'(r_i) + CW1'(3)) < CW1'(r_h)) begin
                    n_k     = r_i + CW'(3);
                    n_state = ST_TRI_I;
                end else begin
                    n_state = ST_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_h         <= '0;
            r_aidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_h         <= n_h;
            r_aidx      <= n_aidx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_anc  <= n_anc;
        r_key  <= n_key;
        r_prev <= n_prev;
        r_p    <= n_p;
        r_t1   <= n_t1;
        r_t2   <= n_t2;
        r_hi   <= n_hi;
        r_hj   <= n_hj;
        r_tk   <= n_tk;
        r_best <= n_best;
        r_out  <= n_out;
    end

    `CHMTA_ASSERT_NOW(a_cmp_start_idle, cmp_start, !cmp_res.busy, "cross unit started while busy")
    `CHMTA_ASSERT_NOW(a_scan_two_deep, r_state == ST_SCAN_CMP, r_h >= CW'(2), "hull test with short stack")
    `CHMTA_ASSERT_NEXT(a_set_closes, in_acc && i_data.last_point, r_cnt == '0, "load count kept after last beat")

endmodule

>>> test/tb_convex_hull_max_triangle_area_core.sv
// testbench for the largest hull triangle block: point sets in, checked areas out
`timescale 1ns / 1ps

module tb_convex_hull_max_triangle_area_core;
    import chmta_pkg::*;

    localparam int STORE_DEPTH = 1024;

    // hull area predictor and queue of outstanding area answers
    class hull_area_board;
        longint    pt_x[STORE_DEPTH];
        longint    pt_y[STORE_DEPTH];
        longint    hx[STORE_DEPTH+1];
        longint    hy[STORE_DEPTH+1];
        int        n_loaded;
        int        lowest;
        t_out_beat want_q[$];
        int        mismatches;
        int        answers_seen;

        function new();
            n_loaded = 0;
            lowest = 0;
            mismatches = 0;
            answers_seen = 0;
        endfunction

        function longint xprod(longint ox, longint oy, longint ax, longint ay,
                               longint bx, longint by);
            return (ax - ox) * (by - oy) - (bx - ox) * (ay - oy);
        endfunction

        function longint span2(longint ax, longint ay, longint bx, longint by);
            return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
        endfunction

        function bit angle_first(int p, int q);
            longint c;
            c = xprod(pt_x[0], pt_y[0], pt_x[p], pt_y[p], pt_x[q], pt_y[q]);
            if (c > 0) return 1;
            return c == 0 && span2(pt_x[p], pt_y[p], pt_x[0], pt_y[0]) <
                             span2(pt_x[q], pt_y[q], pt_x[0], pt_y[0]);
        endfunction

        function void swap_pts(int a, int b);
            longint t;
            t = pt_x[a]; pt_x[a] = pt_x[b]; pt_x[b] = t;
            t = pt_y[a]; pt_y[a] = pt_y[b]; pt_y[b] = t;
        endfunction

        function longint tri_area(int i, int j, int k);
            return xprod(hx[i], hy[i], hx[j], hy[j], hx[k], hy[k]);
        endfunction

        function longint biggest_triangle(int n);
            int     h;
            int     k;
            longint best;
            longint a;
            h = 0;
            best = 0;
            swap_pts(0, lowest);
            for (int i = 2; i < n; i++)
                for (int j = i; j > 1 && angle_first(j, j - 1); j--)
                    swap_pts(j, j - 1);
            for (int i = 0; i < n; i++) begin
                while (h >= 2 && xprod(hx[h-2], hy[h-2], hx[h-1], hy[h-1],
                                       pt_x[i], pt_y[i]) <= 0)
                    h--;
                hx[h] = pt_x[i];
                hy[h] = pt_y[i];
                h++;
            end
            for (int i = 0; i + 2 < h; i++) begin
                k = i + 2;
                for (int j = i + 1; j + 1 < h; j++) begin
                    if (k <= j) k = j + 1;
                    while (k + 1 < h && tri_area(i, j, k + 1) > tri_area(i, j, k)) k++;
                    a = tri_area(i, j, k);
                    if (a > best) best = a;
                end
            end
            return best;
        endfunction

        function void note_point(t_in_beat d);
            longint    x;
            longint    y;
            int        n;
            t_out_beat r;
            x = longint'($signed(d.point_x));
            y = longint'($signed(d.point_y));
            if (n_loaded < STORE_DEPTH) begin
                pt_x[n_loaded] = x;
                pt_y[n_loaded] = y;
                if (n_loaded == 0 || x < pt_x[lowest] ||
                    (x == pt_x[lowest] && y < pt_y[lowest]))
                    lowest = n_loaded;
                n_loaded++;
            end
            if (!d.last_point) return;
            n = n_loaded;
            n_loaded = 0;
            if (n < 3) begin
                r.twice_area = '0;
                r.too_few_points = 1'b1;
            end else begin
                r.twice_area = 32'(biggest_triangle(n));
                r.too_few_points = 1'b0;
            end
            lowest = 0;
            want_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_answer(t_out_beat got);
            t_out_beat w;
            answers_seen++;
            if (want_q.size() == 0) begin
                report_mismatch($sformatf("unexpected answer area=%0d few=%0b",
                                          got.twice_area, got.too_few_points));
                return;
            end
            w = want_q.pop_front();
            if (got.twice_area !== w.twice_area)
                report_mismatch($sformatf("twice_area got %0d want %0d",
                                          got.twice_area, w.twice_area));
            if (got.too_few_points !== w.too_few_points)
                report_mismatch($sformatf("too_few_points got %b want %b",
                                          got.too_few_points, w.too_few_points));
        endtask

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_beat o_data;

    hull_area_board board;
    int tx_idle_pct;
    int rx_idle_pct;
    bit rx_hold_req;
    int points_sent;
    int sets_sent;

    convex_hull_max_triangle_area_core u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #40_000_000;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

    // beat monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) board.note_point(i_data);
        if (i_rst_n && o_valid && i_ready) board.check_answer(o_data);
    end

    // receiver: random stalls, or one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && hold_left == 0) begin
                hold_left = 4000;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else begin
                i_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // called at a falling edge, returns at a falling edge after the beat is taken
    task send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_data.point_x = x;
        i_data.point_y = y;
        i_data.last_point = last;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        points_sent++;
        if (last) sets_sent++;
    endtask

    task wait_drained();
        i_valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    task send_set(int n, int mode);
        logic signed [15:0] x;
        logic signed [15:0] y;
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: begin x = 16'($urandom); y = 16'($urandom); end
                1: begin
                    x = 16'($signed($urandom_range(8)) - 4);
                    y = 16'($signed($urandom_range(8)) - 4);
                end
                2: begin
                    x = $urandom_range(1) ? 16'(16'sh7fff - $urandom_range(3))
                                          : 16'(16'sh8000 + $urandom_range(3));
                    y = $urandom_range(1) ? 16'(16'sh7fff - $urandom_range(3))
                                          : 16'(16'sh8000 + $urandom_range(3));
                end
                default: begin
                    x = 16'($signed($urandom_range(200)) - 100);
                    y = 16'($signed($urandom_range(200)) - 100);
                end
            endcase
            send_point(x, y, i == n - 1);
        end
    endtask

    task random_sets(int n_points);
        int goal;
        int n;
        int r;
        goal = points_sent + n_points;
        while (points_sent < goal) begin
            r = $urandom_range(99);
            if (r < 10) n = $urandom_range(2, 1);
            else if (r < 13) n = $urandom_range(48, 20);
            else n = $urandom_range(9, 3);
            send_set(n, $urandom_range(3));
        end
    endtask

    task directed_sets();
        send_point(16'sd5, -16'sd7, 1'b1);
        send_point(16'sd1, 16'sd1, 1'b0);
        send_point(16'sd2, 16'sd3, 1'b1);
        // collinear, then identical
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd4, 16'sd4, 1'b0);
        send_point(16'sd2, 16'sd2, 1'b1);
        send_point(-16'sd9, 16'sd3, 1'b0);
        send_point(-16'sd9, 16'sd3, 1'b0);
        send_point(-16'sd9, 16'sd3, 1'b1);
        // widest triangle the coordinates allow
        send_point(16'sh7fff, 16'sh8000, 1'b0);
        send_point(16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh8000, 16'sh8000, 1'b1);
        // square with a duplicate, a midpoint and an inner point
        send_point(16'sd10, 16'sd10, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd10, 16'sd0, 1'b0);
        send_point(16'sd5, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd10, 1'b0);
        send_point(16'sd10, 16'sd10, 1'b0);
        send_point(16'sd3, 16'sd4, 1'b1);
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        rx_hold_req = 1'b0;
        points_sent = 0;
        sets_sent = 0;
        tx_idle_pct = 37;
        rx_idle_pct = 50;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_sets();
        random_sets(25);
        wait_drained();

        tx_idle_pct = 50;
        rx_idle_pct = 37;
        random_sets(25);
        // overfull store: points on one ray, last beat dropped but still closes
        for (int i = 0; i < STORE_DEPTH + 6; i++)
            send_point(16'(i), 16'sd0, i == STORE_DEPTH + 5);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        random_sets(30);
        wait_drained();
        i_valid = 1'b0;
        repeat (300) @(posedge i_clk);

        $display("covered %0d points in %0d sets, %0d answers checked",
                 points_sent, sets_sent, board.answers_seen);
        $display("small, degenerate, extreme and overfull sets under stalls and hold-off");
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
